// ===== src/istc_pkg.sv =====
// shared types, constants and helper functions of the imu still / turn classifier
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package istc_pkg;

	localparam int SAMPLE_BITS        = 16;
	localparam int AXES               = 6;
	localparam int GYRO_BASE          = 3;
	localparam int GYROS              = 3;
	localparam int INC_W              = 32;
	localparam int DEV_W              = 31;
	localparam int NRG_W              = 48;
	localparam int WGT_W              = 17;
	localparam int DEFAULT_COUNT_BITS = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_STILL       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_TURN        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_LIMIT        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_COUNT_NEEDED = 3'd6;

	localparam logic [15:0]      RST_SAMPLE_PERIOD     = 16'd328;
	localparam logic [WGT_W-1:0] ONE_Q16               = 17'h10000;
	localparam logic [15:0]      RST_TURN_COUNT_NEEDED = 16'd1;
	localparam logic [15:0]      HALF_Q16              = 16'h8000;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] accel_x;
		logic signed [SAMPLE_BITS-1:0] accel_y;
		logic signed [SAMPLE_BITS-1:0] accel_z;
		logic signed [SAMPLE_BITS-1:0] gyro_x;
		logic signed [SAMPLE_BITS-1:0] gyro_y;
		logic signed [SAMPLE_BITS-1:0] gyro_z;
	} sample_t;

	typedef struct packed {
		logic             is_still;
		logic             is_turning;
		logic             is_straight;
		logic [NRG_W-1:0] turn_energy;
	} result_t;

	typedef struct packed {
		logic [15:0]      sample_period;
		logic [WGT_W-1:0] alpha_still;
		logic [WGT_W-1:0] alpha_turn;
		logic [DEV_W-1:0] accel_limit;
		logic [DEV_W-1:0] gyro_limit;
		logic [NRG_W-1:0] turn_limit;
		logic [15:0]      turn_count_needed;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic inc;
		logic sqr;
		logic mean;
		logic devmul;
		logic devupd;
		logic nrg;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} stat_t;

	function automatic logic [WGT_W-1:0] weight(input logic [WGT_W-1:0] a);
		return (a > ONE_Q16) ? ONE_Q16 : a;
	endfunction

endpackage

// ===== src/istc_cfg.sv =====
// configuration register bank of the imu still / turn classifier
// depends on istc_pkg
`timescale 1ns / 1ps

module istc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [istc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [istc_pkg::CFG_DATA_W-1:0]   wr_data,
	output istc_pkg::cfg_t                    cfg
);
	import istc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_period     <= RST_SAMPLE_PERIOD;
			cfg_q.alpha_still       <= ONE_Q16;
			cfg_q.alpha_turn        <= ONE_Q16;
			cfg_q.accel_limit       <= '0;
			cfg_q.gyro_limit        <= '0;
			cfg_q.turn_limit        <= '0;
			cfg_q.turn_count_needed <= RST_TURN_COUNT_NEEDED;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SAMPLE_PERIOD:     cfg_q.sample_period     <= wr_data[15:0];
				CFG_ALPHA_STILL:       cfg_q.alpha_still       <= wr_data[WGT_W-1:0];
				CFG_ALPHA_TURN:        cfg_q.alpha_turn        <= wr_data[WGT_W-1:0];
				CFG_ACCEL_LIMIT:       cfg_q.accel_limit       <= wr_data[DEV_W-1:0];
				CFG_GYRO_LIMIT:        cfg_q.gyro_limit        <= wr_data[DEV_W-1:0];
				CFG_TURN_LIMIT:        cfg_q.turn_limit        <= wr_data[NRG_W-1:0];
				CFG_TURN_COUNT_NEEDED: cfg_q.turn_count_needed <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/istc_ctrl.sv =====
// sequencer of the imu still / turn classifier, steps the datapath once per sample
// depends on istc_pkg
`timescale 1ns / 1ps

module istc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           sample_valid,
	output logic           sample_stall,
	input  logic           result_stall,
	input  istc_pkg::stat_t stat,
	output istc_pkg::cmd_t  cmd
);
	import istc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_INC    = 8'b0000_0010,
		S_SQR    = 8'b0000_0100,
		S_MEAN   = 8'b0000_1000,
		S_DEVMUL = 8'b0001_0000,
		S_DEVUPD = 8'b0010_0000,
		S_NRG    = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   slot_free;

	assign slot_free = !stat.out_full || !result_stall;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE:   if (sample_valid) state_next = S_INC;
			S_INC:    state_next = S_SQR;
			S_SQR:    state_next = S_MEAN;
			S_MEAN:   state_next = S_DEVMUL;
			S_DEVMUL: state_next = S_DEVUPD;
			S_DEVUPD: state_next = S_NRG;
			S_NRG:    state_next = S_FIN;
			S_FIN:    if (slot_free) state_next = S_IDLE;
			default:  state_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign sample_stall = (state_q != S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && sample_valid;
		cmd.inc    = (state_q == S_INC);
		cmd.sqr    = (state_q == S_SQR);
		cmd.mean   = (state_q == S_MEAN);
		cmd.devmul = (state_q == S_DEVMUL);
		cmd.devupd = (state_q == S_DEVUPD);
		cmd.nrg    = (state_q == S_NRG);
		cmd.fin    = (state_q == S_FIN) && slot_free;
	end

endmodule

// ===== src/istc_dp.sv =====
// datapath of the imu still / turn classifier: per-axis lanes, energy path, result register
// depends on istc_pkg
`timescale 1ns / 1ps

module istc_dp #(
	parameter int COUNT_BITS = istc_pkg::DEFAULT_COUNT_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  istc_pkg::cmd_t    cmd,
	input  istc_pkg::cfg_t    cfg,
	input  istc_pkg::sample_t sample,
	input  logic              result_stall,
	output istc_pkg::stat_t   stat,
	output logic              result_valid,
	output istc_pkg::result_t result
);
	import istc_pkg::*;

	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic signed [SAMPLE_BITS-1:0] raw_q   [AXES];
	logic signed [INC_W-1:0]       inc_q   [AXES];
	logic [49:0]                   mprod_q [AXES];
	logic                          msign_q [AXES];
	logic [61:0]                   sq_q    [GYROS];
	logic [50:0]                   dprod_q [AXES];
	logic                          dsign_q [AXES];
	logic [40:0]                   e_lo_q;
	logic [40:0]                   e_hi_q;
	logic [NRG_W-1:0]              s_q;

	logic signed [INC_W-1:0]       mean_q  [AXES];
	logic [DEV_W-1:0]              dev_q   [AXES];
	logic [NRG_W-1:0]              energy_q;
	logic [COUNT_BITS-1:0]         count_q;
	logic                          primed_q;
	logic                          result_valid_q;
	result_t                       result_q;

	logic [WGT_W-1:0]              as_w;
	logic [WGT_W-1:0]              at_w;
	logic signed [32:0]            inc_full [AXES];
	logic [30:0]                   g_mag    [GYROS];
	logic signed [32:0]            dm       [AXES];
	logic [32:0]                   dm_mag   [AXES];
	logic [50:0]                   mround   [AXES];
	logic [33:0]                   mt       [AXES];
	logic signed [34:0]            mean_new [AXES];
	logic signed [32:0]            dx       [AXES];
	logic signed [33:0]            dd       [AXES];
	logic [33:0]                   dd_mag   [AXES];
	logic [51:0]                   dround   [AXES];
	logic [35:0]                   dt       [AXES];
	logic signed [36:0]            dev_new  [AXES];
	logic [DEV_W-1:0]              dev_clamp[AXES];
	logic [63:0]                   sq_sum;
	logic signed [48:0]            de;
	logic [47:0]                   de_mag;
	logic [65:0]                   eround;
	logic [49:0]                   et;
	logic signed [50:0]            e_new;
	logic [NRG_W-1:0]              e_clamp;
	logic                          above;
	logic [COUNT_BITS-1:0]         count_next;
	logic                          turning;
	logic                          still;

	assign as_w = weight(cfg.alpha_still);
	assign at_w = weight(cfg.alpha_turn);

	// lane arithmetic
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			inc_full[i] = raw_q[i] * $signed({1'b0, cfg.sample_period});
			dm[i]       = $signed({inc_q[i][INC_W-1], inc_q[i]})
			            - $signed({mean_q[i][INC_W-1], mean_q[i]});
			dm_mag[i]   = dm[i][32] ? 33'(-dm[i]) : 33'(dm[i]);
			mround[i]   = {1'b0, mprod_q[i]} + 51'(HALF_Q16);
			mt[i]       = mround[i][49:16];
			mean_new[i] = msign_q[i]
			            ? $signed({{3{mean_q[i][INC_W-1]}}, mean_q[i]}) - $signed({1'b0, mt[i]})
			            : $signed({{3{mean_q[i][INC_W-1]}}, mean_q[i]}) + $signed({1'b0, mt[i]});
			dx[i]       = $signed({inc_q[i][INC_W-1], inc_q[i]})
			            - $signed({mean_q[i][INC_W-1], mean_q[i]});
			dd[i]       = $signed({dx[i][32], dx[i]}) - $signed({3'b000, dev_q[i]});
			dd_mag[i]   = dd[i][33] ? 34'(-dd[i]) : 34'(dd[i]);
			dround[i]   = {1'b0, dprod_q[i]} + 52'(HALF_Q16);
			dt[i]       = dround[i][51:16];
			dev_new[i]  = dsign_q[i]
			            ? $signed({6'b0, dev_q[i]}) - $signed({1'b0, dt[i]})
			            : $signed({6'b0, dev_q[i]}) + $signed({1'b0, dt[i]});
			if (dev_new[i][36]) begin
				dev_clamp[i] = '0;
			end else if (|dev_new[i][35:31]) begin
				dev_clamp[i] = '1;
			end else begin
				dev_clamp[i] = dev_new[i][30:0];
			end
		end
		for (int j = 0; j < GYROS; j++) begin
			g_mag[j] = inc_q[GYRO_BASE+j][INC_W-1] ? 31'(-inc_q[GYRO_BASE+j])
			                                        : 31'(inc_q[GYRO_BASE+j]);
		end
	end

	// energy path
	always_comb begin
		sq_sum = 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]) + 64'(HALF_Q16);
		de     = $signed({1'b0, s_q}) - $signed({1'b0, energy_q});
		de_mag = de[48] ? 48'(-de) : 48'(de);
		eround = 66'({e_hi_q, 24'b0}) + 66'(e_lo_q) + 66'(HALF_Q16);
		et     = eround[65:16];
		e_new  = de[48] ? $signed({3'b000, energy_q}) - $signed({1'b0, et})
		                : $signed({3'b000, energy_q}) + $signed({1'b0, et});
		if (e_new[50]) begin
			e_clamp = '0;
		end else if (|e_new[49:48]) begin
			e_clamp = '1;
		end else begin
			e_clamp = e_new[47:0];
		end
	end

	// classification
	always_comb begin
		above = energy_q > cfg.turn_limit;
		if (!above) begin
			count_next = '0;
		end else if (&count_q) begin
			count_next = count_q;
		end else begin
			count_next = count_q + 1'b1;
		end
		turning = above && (CMP_W'(count_next) >= CMP_W'(cfg.turn_count_needed));
		still   = 1'b1;
		for (int i = 0; i < AXES; i++) begin
			if (i < GYRO_BASE) begin
				if (dev_q[i] >= cfg.accel_limit) still = 1'b0;
			end else begin
				if (dev_q[i] >= cfg.gyro_limit) still = 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q[0] <= sample.accel_x;
			raw_q[1] <= sample.accel_y;
			raw_q[2] <= sample.accel_z;
			raw_q[3] <= sample.gyro_x;
			raw_q[4] <= sample.gyro_y;
			raw_q[5] <= sample.gyro_z;
		end
		for (int i = 0; i < AXES; i++) begin
			if (cmd.inc) inc_q[i] <= inc_full[i][INC_W-1:0];
			if (cmd.sqr) begin
				mprod_q[i] <= as_w * dm_mag[i];
				msign_q[i] <= dm[i][32];
			end
			if (cmd.devmul) begin
				dprod_q[i] <= as_w * dd_mag[i];
				dsign_q[i] <= dd[i][33];
			end
		end
		for (int j = 0; j < GYROS; j++) begin
			if (cmd.sqr) sq_q[j] <= g_mag[j] * g_mag[j];
		end
		if (cmd.mean)   s_q    <= sq_sum[63:16];
		if (cmd.devmul) e_lo_q <= at_w * de_mag[23:0];
		if (cmd.devupd) e_hi_q <= at_w * de_mag[47:24];
		if (cmd.fin) begin
			result_q.is_still    <= still;
			result_q.is_turning  <= turning;
			result_q.is_straight <= !still && !turning;
			result_q.turn_energy <= energy_q;
		end
	end

	// averaged state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				mean_q[i] <= '0;
				dev_q[i]  <= '0;
			end
			energy_q       <= '0;
			count_q        <= '0;
			primed_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			for (int i = 0; i < AXES; i++) begin
				if (cmd.mean)   mean_q[i] <= primed_q ? mean_new[i][INC_W-1:0] : inc_q[i];
				if (cmd.devupd) dev_q[i]  <= primed_q ? dev_clamp[i] : '0;
			end
			if (cmd.nrg) energy_q <= primed_q ? e_clamp : s_q;
			if (cmd.fin) begin
				count_q  <= count_next;
				primed_q <= 1'b1;
			end
			if (cmd.fin) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_full = result_valid_q;
	assign result_valid  = result_valid_q;
	assign result        = result_q;

endmodule

// ===== src/imu_still_turn_classifier.sv =====
// top level of the imu still / turn classifier
// depends on istc_pkg, istc_cfg, istc_ctrl, istc_dp
`timescale 1ns / 1ps

// Usage
// sample channel: sample_valid / sample_stall / sample carry one IMU reading,
// three accelerometer and three gyroscope axes; a transaction completes on a
// rising edge with sample_valid high and sample_stall low.
// result channel: result_valid / result_stall / result carry the still,
// turning and straight flags and the averaged turn energy, one per sample.
// configuration: wr_en / wr_index / wr_data write one register per edge;
// write only while no sample is in flight.
// sequencing: a new sample is taken only after the last one has finished
// its final step; the sequencer walks seven datapath steps (scale, square
// and mean product, mean update, deviation product, deviation update,
// energy update, classify) and the energy product is formed in two halves
// on a 17 by 24 bit multiplier.
// the result sits in an output register, so the next sample is taken while a
// result is still held by result_stall; a sample finished behind a stalled
// result waits in its last step until the register frees.
// reset: registers return to their defaults, averages and counters clear,
// and the first sample after reset seeds the averages.
module imu_still_turn_classifier #(
	parameter int COUNT_BITS = istc_pkg::DEFAULT_COUNT_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  istc_pkg::sample_t               sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output istc_pkg::result_t               result,
	input  logic                            wr_en,
	input  logic [istc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [istc_pkg::CFG_DATA_W-1:0] wr_data
);
	import istc_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	istc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	istc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	istc_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.sample       (sample),
		.result_stall (result_stall),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("sample taken while a previous one is in flight");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath step commanded");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> result_valid)
		else $error("finished sample did not reach the result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin && result_valid) |-> !result_stall)
		else $error("held result overwritten");

endmodule
